// ===== sv/psfn_pkg.sv =====
`default_nettype none
package psfn_pkg;

	localparam int CAND_W = 14;
	localparam int DIV_W = 7;
	localparam int CNT_W = 11;
	localparam int SUM_W = 24;
	localparam int IN_TDATA_W = 16;
	localparam int OUT_TDATA_W = 24;

	localparam int DIV_STEPS = CAND_W;
	localparam int STEP_W = $clog2(DIV_STEPS);

	localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(1024);
	localparam logic [CAND_W-1:0] FIRST_PRIME = CAND_W'(2);
	localparam logic [DIV_W-1:0] FIRST_DIVISOR = DIV_W'(2);
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TEST,
		ST_DIV,
		ST_EVAL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic start_div;
		logic add_prime;
		logic next_cand;
		logic next_div;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic count_reached;
		logic square_above;
		logic div_done;
		logic rem_zero;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ===== sv/psfn_divider.sv =====
`default_nettype none
module psfn_divider (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [psfn_pkg::CAND_W-1:0]   dividend,
	input  wire logic [psfn_pkg::DIV_W-1:0]    divisor,
	output logic                               busy,
	output logic                               done,
	output logic                               rem_zero
);

	logic                          busy_q;
	logic                          done_q;
	logic [psfn_pkg::STEP_W-1:0]   step_q;
	logic [psfn_pkg::CAND_W-1:0]   dvd_q;
	logic [psfn_pkg::DIV_W-1:0]    rem_q;
	logic [psfn_pkg::DIV_W:0]      trial;
	logic [psfn_pkg::DIV_W:0]      diff;
	logic [psfn_pkg::DIV_W-1:0]    rem_next;

	// one restoring step per cycle, msb first
	always_comb begin
		trial = {rem_q, dvd_q[psfn_pkg::CAND_W-1]};
		diff = trial - {1'b0, divisor};
		if (trial >= {1'b0, divisor}) begin
			rem_next = diff[psfn_pkg::DIV_W-1:0];
		end else begin
			rem_next = trial[psfn_pkg::DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= psfn_pkg::STEP_W'(psfn_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[psfn_pkg::CAND_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem_zero = (rem_q == '0);

endmodule
`default_nettype wire

// ===== sv/psfn_datapath.sv =====
`default_nettype none
module psfn_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire psfn_pkg::cmd_t                     cmd,
	output psfn_pkg::status_t                       status,
	input  wire logic [psfn_pkg::IN_TDATA_W-1:0]    in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [psfn_pkg::OUT_TDATA_W-1:0]        out_data
);

	logic [psfn_pkg::CAND_W-1:0]   cand_q;
	logic [psfn_pkg::DIV_W-1:0]    div_q;
	logic [psfn_pkg::CNT_W-1:0]    found_q;
	logic [psfn_pkg::CNT_W-1:0]    target_q;
	logic [psfn_pkg::SUM_W-1:0]    sum_q;
	logic                          out_valid_q;
	logic [psfn_pkg::SUM_W-1:0]    out_data_q;

	logic [psfn_pkg::CNT_W-1:0]    asked;
	logic [2*psfn_pkg::DIV_W-1:0]  square;
	logic [psfn_pkg::SUM_W:0]      sum_wide;
	logic                          div_busy;
	logic                          div_done;
	logic                          rem_zero;

	always_comb begin
		asked = in_data[psfn_pkg::CNT_W-1:0];
		if (asked > psfn_pkg::MAX_COUNT) begin
			asked = psfn_pkg::MAX_COUNT;
		end
	end

	assign square = div_q * div_q;
	assign sum_wide = {1'b0, sum_q} + {{(psfn_pkg::SUM_W + 1 - psfn_pkg::CAND_W){1'b0}}, cand_q};

	psfn_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_div),
		.dividend (cand_q),
		.divisor  (div_q),
		.busy     (div_busy),
		.done     (div_done),
		.rem_zero (rem_zero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= psfn_pkg::FIRST_PRIME;
			div_q <= psfn_pkg::FIRST_DIVISOR;
			found_q <= '0;
			target_q <= '0;
			sum_q <= '0;
		end else begin
			if (cmd.load) begin
				cand_q <= psfn_pkg::FIRST_PRIME;
				div_q <= psfn_pkg::FIRST_DIVISOR;
				found_q <= '0;
				target_q <= asked;
				sum_q <= '0;
			end
			if (cmd.add_prime) begin
				found_q <= found_q + 1'b1;
				if (sum_wide[psfn_pkg::SUM_W]) begin
					sum_q <= psfn_pkg::SUM_MAX;
				end else begin
					sum_q <= sum_wide[psfn_pkg::SUM_W-1:0];
				end
			end
			if (cmd.next_cand) begin
				cand_q <= cand_q + 1'b1;
				div_q <= psfn_pkg::FIRST_DIVISOR;
			end
			if (cmd.next_div) begin
				div_q <= div_q + 1'b1;
			end
		end
	end

	// output register, frees the search side while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= sum_q;
		end
	end

	always_comb begin
		status.count_reached = (found_q == target_q);
		status.square_above = (square > cand_q);
		status.div_done = div_done;
		status.rem_zero = rem_zero;
		status.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	a_found_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		found_q <= target_q)
		else $error("found count passed target");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_div |-> !div_busy)
		else $error("divider restarted while busy");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q && out_data_q == $past(sum_q))
		else $error("emitted sum not held in output register");

	a_cand_floor: assert property (@(posedge clk) disable iff (!arst_n)
		cand_q >= psfn_pkg::FIRST_PRIME && div_q >= psfn_pkg::FIRST_DIVISOR)
		else $error("candidate or divisor below start value");

endmodule
`default_nettype wire

// ===== sv/psfn_ctrl.sv =====
`default_nettype none
module psfn_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire psfn_pkg::status_t    status,
	output psfn_pkg::cmd_t            cmd
);

	psfn_pkg::state_t state_q;
	psfn_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psfn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			psfn_pkg::ST_IDLE: begin
				if (in_valid) state_d = psfn_pkg::ST_CHECK;
			end
			psfn_pkg::ST_CHECK: begin
				if (status.count_reached) state_d = psfn_pkg::ST_DONE;
				else state_d = psfn_pkg::ST_TEST;
			end
			psfn_pkg::ST_TEST: begin
				if (status.square_above) state_d = psfn_pkg::ST_CHECK;
				else state_d = psfn_pkg::ST_DIV;
			end
			psfn_pkg::ST_DIV: begin
				if (status.div_done) state_d = psfn_pkg::ST_EVAL;
			end
			psfn_pkg::ST_EVAL: begin
				if (status.rem_zero) state_d = psfn_pkg::ST_CHECK;
				else state_d = psfn_pkg::ST_TEST;
			end
			psfn_pkg::ST_DONE: begin
				if (status.out_free) state_d = psfn_pkg::ST_IDLE;
			end
			default: state_d = psfn_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			psfn_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			psfn_pkg::ST_CHECK: begin
			end
			psfn_pkg::ST_TEST: begin
				if (status.square_above) begin
					cmd.add_prime = 1'b1;
					cmd.next_cand = 1'b1;
				end else begin
					cmd.start_div = 1'b1;
				end
			end
			psfn_pkg::ST_DIV: begin
			end
			psfn_pkg::ST_EVAL: begin
				if (status.rem_zero) cmd.next_cand = 1'b1;
				else cmd.next_div = 1'b1;
			end
			psfn_pkg::ST_DONE: begin
				cmd.emit = status.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/prime_sum_first_n_core.sv =====
// prime_sum_first_n_core: sum of the first n primes by trial division
//
// slave side (s_*): one beat carries a count n in s_tdata[10:0]; counts above
// 1024 are clamped to 1024. the block takes one count at a time: s_tready is
// high only while no search is running.
// master side (m_*): one beat per count, m_tdata[23:0] holds the sum of the
// first n primes (0 for n = 0).
// n = 0 goes from the count check straight to done, which loads the output
// register and returns to idle, so s_tready rises with m_tvalid. otherwise
// each candidate passes a count check, then per trial divisor a bound test
// that issues the division, the bit-serial remainder unit (one step per
// dividend bit) up to its done flag, and an eval; a prime ends at its last
// bound test. the trial divider thus sets the run time.
// the result sits in an output register: a stalled receiver holds the
// finished sum there while the next count is already accepted and searched;
// that search waits at its end only if the earlier sum is still unclaimed.
// reset (arst_n low, asynchronous) drops m_tvalid, returns the controller
// to idle and sets the search registers to their start values.
`default_nettype none
module prime_sum_first_n_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [psfn_pkg::IN_TDATA_W-1:0]       s_tdata,  // [10:0] prime_count, [15:11] zero
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic [psfn_pkg::OUT_TDATA_W-1:0]           m_tdata   // [23:0] prime_total
);

	// commands from the controller, status back from the datapath
	psfn_pkg::cmd_t    cmd;
	psfn_pkg::status_t status;

	// sequencer: accept count, check count, test divisor bound, run remainder, evaluate, emit
	psfn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// candidate, divisor, counters, sum, remainder unit and output register
	psfn_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire
